FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge while reset is released.
`define LBCD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

// Condition that must never be seen while reset is released.
`define LBCD_ASSERT_NEVER(name, clk, rst_n, cond) \
  `LBCD_ASSERT(name, clk, rst_n, !(cond))

`endif

FILE: rtl/core/lbcd_pkg.sv
// Types and constants of the LRU block cache directory.
`timescale 1ns / 1ps
`default_nettype none

package lbcd_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned BLOCK_BITS_DEF = 32;
  localparam int unsigned REF_BITS_DEF   = 16;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned BLOCK_IN_W = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned THR_W      = 7;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [THR_W-1:0] THR_RESET = 7'd32;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_DONE     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_COUNTERR = 3'd5
  } status_e;

  typedef struct packed {
    logic load;
    logic ev_init;
    logic ev_match;
    logic ev_step;
    logic scan_start;
    logic scan_run;
    logic ref_read;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic in_acquire;
    logic ev_skip;
    logic ev_done;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/lbcd_ctrl.sv
// Sequencer of the directory: eviction walk, tag scan, count read, result.
`timescale 1ns / 1ps
`default_nettype none

module lbcd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  output logic                 s_ready_o,
  input  wire lbcd_pkg::dp_sts_t sts_i,
  output lbcd_pkg::dp_cmd_t    cmd_o
);
  import lbcd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EV_MATCH = 6'b000010,
    S_EV_STEP  = 6'b000100,
    S_SCAN     = 6'b001000,
    S_REFRD    = 6'b010000,
    S_FINISH   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_acquire) begin
            cmd_o.ev_init = 1'b1;
            if (sts_i.ev_skip) begin
              cmd_o.scan_start = 1'b1;
              state_d = S_SCAN;
            end else begin
              state_d = S_EV_MATCH;
            end
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_EV_MATCH: begin
        cmd_o.ev_match = 1'b1;
        state_d = S_EV_STEP;
      end
      S_EV_STEP: begin
        cmd_o.ev_step = 1'b1;
        if (sts_i.ev_done) begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end else begin
          state_d = S_EV_MATCH;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = S_REFRD;
        end else if (sts_i.scan_end) begin
          state_d = S_FINISH;
        end
      end
      S_REFRD: begin
        cmd_o.ref_read = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign s_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lbcd_datapath.sv
// Directory storage, recency cells, tag scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module lbcd_datapath #(
  parameter int unsigned CAPACITY   = lbcd_pkg::CAPACITY_DEF,
  parameter int unsigned BLOCK_BITS = lbcd_pkg::BLOCK_BITS_DEF,
  parameter int unsigned REF_BITS   = lbcd_pkg::REF_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lbcd_pkg::THR_W-1:0]       cfg_wdata_i,
  input  wire logic [lbcd_pkg::OP_W-1:0]        op_i,
  input  wire logic [lbcd_pkg::BLOCK_IN_W-1:0]  block_i,
  input  wire lbcd_pkg::dp_cmd_t                cmd_i,
  output lbcd_pkg::dp_sts_t                     sts_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [lbcd_pkg::STATUS_W-1:0]         out_status_o,
  output logic [lbcd_pkg::SLOT_W-1:0]           out_slot_o,
  output logic [lbcd_pkg::COUNT_W-1:0]          out_count_o
);
  import lbcd_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  // Request registers and configuration.
  opcode_e               op_q;
  logic [BLOCK_BITS-1:0] tag_q;
  logic [THR_W-1:0]      thr_q;

  // Directory state.
  logic [CNT_W-1:0]    count_q;
  logic [CAPACITY-1:0] used_q, pinned_q, busy_q;
  logic [IDX_W-1:0]    rank_q [CAPACITY];
  logic [BLOCK_BITS-1:0] tag_mem [CAPACITY];
  logic [REF_BITS-1:0]   refs_mem [CAPACITY];

  // Eviction walk.
  logic [CNT_W-1:0]    r_q, r_dec;
  logic [IDX_W-1:0]    r_m1;
  logic [CAPACITY-1:0] match_q;
  logic                idle_hit;
  logic [CNT_W-1:0]    cnt_dec, cnt_inc;

  // Tag scan.
  logic [IDX_W-1:0]      scan_addr_q, cmp_idx_q, k_q, free_q;
  logic                  cmp_vld_q, hit_q, free_found_q;
  logic [BLOCK_BITS-1:0] tag_rd_q;
  logic [REF_BITS-1:0]   refs_rd_q;
  logic                  scan_hit;

  // Result decision.
  status_e             res_status;
  logic [IDX_W-1:0]    res_slot;
  logic                do_move, do_alloc, do_pin, do_unpin, refs_we;
  logic [IDX_W-1:0]    refs_widx;
  logic [REF_BITS-1:0] refs_wval;
  logic [IDX_W-1:0]    rank_k;
  logic [CNT_W-1:0]    count_new;
  logic                out_free;

  // Output register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [COUNT_W-1:0]  out_count_q;

  assign r_dec    = r_q - CNT_W'(1);
  assign r_m1     = r_dec[IDX_W-1:0];
  assign cnt_dec  = count_q - CNT_W'(1);
  assign cnt_inc  = count_q + CNT_W'(1);
  assign idle_hit = |(match_q & ~pinned_q & ~busy_q);
  assign scan_hit = cmp_vld_q && used_q[cmp_idx_q] && (tag_rd_q == tag_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign rank_k   = rank_q[k_q];

  always_comb begin
    sts_o.in_acquire = (op_i == OP_ACQUIRE);
    sts_o.ev_skip    = (CMP_W'(count_q) < CMP_W'(thr_q)) || (count_q == '0);
    // The walk ends once an eviction drops the count below the threshold
    // or the least-recent end has been walked down to rank zero.
    sts_o.ev_done    = (idle_hit && (CMP_W'(cnt_dec) < CMP_W'(thr_q))) ||
                       (r_q == CNT_W'(1));
    sts_o.scan_hit   = scan_hit;
    sts_o.scan_end   = cmp_vld_q && (cmp_idx_q == IDX_W'(CAPACITY - 1));
    sts_o.out_free   = out_free;
  end

  always_comb begin
    res_status = ST_NOTFOUND;
    res_slot   = k_q;
    do_move    = 1'b0;
    do_alloc   = 1'b0;
    do_pin     = 1'b0;
    do_unpin   = 1'b0;
    refs_we    = 1'b0;
    refs_widx  = k_q;
    refs_wval  = refs_rd_q;
    case (op_q)
      OP_ACQUIRE: begin
        if (hit_q) begin
          if (refs_rd_q == '1) begin
            res_status = ST_COUNTERR;
          end else begin
            res_status = ST_HIT;
            do_move    = 1'b1;
            refs_we    = 1'b1;
            refs_wval  = refs_rd_q + REF_BITS'(1);
          end
        end else if (free_found_q) begin
          res_status = ST_MISS;
          res_slot   = free_q;
          do_alloc   = 1'b1;
          refs_we    = 1'b1;
          refs_widx  = free_q;
          refs_wval  = REF_BITS'(1);
        end else begin
          res_status = ST_FULL;
          res_slot   = '0;
        end
      end
      OP_RELEASE: begin
        if (!hit_q) begin
          res_slot = '0;
        end else if (refs_rd_q == '0) begin
          res_status = ST_COUNTERR;
        end else begin
          res_status = ST_DONE;
          refs_we    = 1'b1;
          refs_wval  = refs_rd_q - REF_BITS'(1);
        end
      end
      OP_PIN, OP_UNPIN: begin
        if (!hit_q) begin
          res_slot = '0;
        end else begin
          res_status = ST_DONE;
          do_pin     = (op_q == OP_PIN);
          do_unpin   = (op_q == OP_UNPIN);
        end
      end
      default: begin
        res_slot = '0;
      end
    endcase
    count_new = do_alloc ? cnt_inc : count_q;
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THR_RESET;
      count_q      <= '0;
      used_q       <= '0;
      pinned_q     <= '0;
      busy_q       <= '0;
      r_q          <= '0;
      scan_addr_q  <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.ev_init) begin
        r_q <= count_q;
      end
      if (cmd_i.ev_step) begin
        r_q <= r_dec;
        if (idle_hit) begin
          used_q  <= used_q & ~match_q;
          count_q <= cnt_dec;
        end
      end
      if (cmd_i.scan_start) begin
        scan_addr_q  <= '0;
        cmp_vld_q    <= 1'b0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end
      if (cmd_i.scan_run) begin
        scan_addr_q <= scan_addr_q + IDX_W'(1);
        cmp_vld_q   <= 1'b1;
        if (scan_hit) begin
          hit_q <= 1'b1;
        end
        if (cmp_vld_q && !used_q[cmp_idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        count_q     <= count_new;
        if (refs_we) begin
          busy_q[refs_widx] <= (refs_wval != '0);
        end
        if (do_alloc) begin
          used_q[free_q]   <= 1'b1;
          pinned_q[free_q] <= 1'b0;
        end
        if (do_pin) begin
          pinned_q[k_q] <= 1'b1;
        end
        if (do_unpin) begin
          pinned_q[k_q] <= 1'b0;
        end
      end
    end
  end

  // Payload registers, recency cells and memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_e'(op_i);
      tag_q <= BLOCK_BITS'(block_i);
    end
    if (cmd_i.ev_match) begin
      for (int e = 0; e < CAPACITY; e++) begin
        match_q[e] <= used_q[e] && (rank_q[e] == r_m1);
      end
    end
    if (cmd_i.ev_step && idle_hit) begin
      for (int e = 0; e < CAPACITY; e++) begin
        if (used_q[e] && (rank_q[e] > r_m1)) begin
          rank_q[e] <= rank_q[e] - IDX_W'(1);
        end
      end
    end
    if (cmd_i.scan_run) begin
      tag_rd_q  <= tag_mem[scan_addr_q];
      cmp_idx_q <= scan_addr_q;
      if (scan_hit) begin
        k_q <= cmp_idx_q;
      end
      if (cmp_vld_q && !used_q[cmp_idx_q] && !free_found_q) begin
        free_q <= cmp_idx_q;
      end
    end
    if (cmd_i.ref_read) begin
      refs_rd_q <= refs_mem[k_q];
    end
    if (cmd_i.finish) begin
      if (refs_we) begin
        refs_mem[refs_widx] <= refs_wval;
      end
      if (do_alloc) begin
        tag_mem[free_q] <= tag_q;
      end
      for (int e = 0; e < CAPACITY; e++) begin
        if (do_alloc) begin
          if (IDX_W'(e) == free_q) begin
            rank_q[e] <= '0;
          end else if (used_q[e]) begin
            rank_q[e] <= rank_q[e] + IDX_W'(1);
          end
        end else if (do_move) begin
          if (IDX_W'(e) == k_q) begin
            rank_q[e] <= '0;
          end else if (used_q[e] && (rank_q[e] < rank_k)) begin
            rank_q[e] <= rank_q[e] + IDX_W'(1);
          end
        end
      end
      out_status_q <= res_status;
      out_slot_q   <= SLOT_W'(res_slot);
      out_count_q  <= COUNT_W'(count_new);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_count_o  = out_count_q;

endmodule

`default_nettype wire

FILE: rtl/core/lru_block_cache_directory_top.sv
// Top level of the LRU block cache directory.
//
// Requests arrive on the slave stream: tuser carries the opcode (acquire,
// release, pin, unpin) and tdata the block number. Each request yields one
// result on the master stream: tuser carries the status, tdata the slot and
// the cached entry count after the request. The user must set the eviction
// threshold through cfg_we_i / cfg_wdata_i only while the block is idle; the
// block itself does not enforce this. One request is worked on at a time.
// It is loaded, then for an acquire at or above the threshold the eviction
// walk goes from the least-recent end, a match step and an update step for
// each rank, then the tag scan reads the directory slots one at a time
// through the single tag memory port, with a registered tag read; on a hit
// the reference count is read, and at last the result is written. A request
// that misses scans all CAPACITY slots.
// The result waits in an output register; a new request is accepted while
// it waits, and is held in its last step until the receiver takes the old
// result. Reset empties the directory and sets the threshold to 32; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_block_cache_directory_top #(
  parameter int unsigned CAPACITY   = lbcd_pkg::CAPACITY_DEF,
  parameter int unsigned BLOCK_BITS = lbcd_pkg::BLOCK_BITS_DEF,
  parameter int unsigned REF_BITS   = lbcd_pkg::REF_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lbcd_pkg::THR_W-1:0]       cfg_wdata_i,   // eviction limit
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [lbcd_pkg::BLOCK_IN_W-1:0]  s_axis_tdata,  // [31:0] block_number
  input  wire logic [lbcd_pkg::OP_W-1:0]        s_axis_tuser,  // [1:0] opcode
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [lbcd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // [5:0] slot, [12:6] cached_count
  output logic [lbcd_pkg::STATUS_W-1:0]         m_axis_tuser   // [2:0] status
);
  import lbcd_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [SLOT_W-1:0]  out_slot;
  logic [COUNT_W-1:0] out_count;

  lbcd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lbcd_datapath #(
    .CAPACITY   (CAPACITY),
    .BLOCK_BITS (BLOCK_BITS),
    .REF_BITS   (REF_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_i         (s_axis_tuser),
    .block_i      (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_slot_o   (out_slot),
    .out_count_o  (out_count)
  );

  assign m_axis_tdata = {(OUT_DATA_W - SLOT_W - COUNT_W)'(0), out_count, out_slot};

endmodule

`default_nettype wire

FILE: rtl/core/lbcd_checker.sv
// Port-level checker of the directory, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lbcd_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             cfg_we_i,
  input wire logic [lbcd_pkg::THR_W-1:0]       cfg_wdata_i,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [lbcd_pkg::BLOCK_IN_W-1:0]  s_axis_tdata,
  input wire logic [lbcd_pkg::OP_W-1:0]        s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [lbcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic [lbcd_pkg::STATUS_W-1:0]    m_axis_tuser
);
  import lbcd_pkg::*;

  // A result is never withdrawn before the receiver takes it.
  `LBCD_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  `LBCD_ASSERT_NEVER(a_status_range, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser > ST_COUNTERR))

  // Requests that find no entry report slot zero.
  `LBCD_ASSERT(a_none_slot_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == ST_NOTFOUND || m_axis_tuser == ST_FULL)
      |-> m_axis_tdata[5:0] == '0)

  // A fill leaves at least the new entry in the directory.
  `LBCD_ASSERT_NEVER(a_miss_count, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == ST_MISS) && (m_axis_tdata[12:6] == '0))

endmodule

bind lru_block_cache_directory_top lbcd_checker u_checker (.*);

`default_nettype wire
